>>> sv/qph_pkg.sv
package qph_pkg;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 31;
    localparam int SLOT_W  = 4;
    localparam int COEF_W  = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COEF_W-1:0]  t_coef;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_DELETE = 2'd2;

    localparam logic REG_LINEAR = 1'b0;
    localparam logic REG_SQUARE = 1'b1;

    localparam t_coef LINEAR_RESET = 4'd1;
    localparam t_coef SQUARE_RESET = 4'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_RESP
    } t_state;

endpackage

>>> sv/qph_req_if.sv
interface qph_req_if
    import qph_pkg::*;
();
    logic   valid;
    logic   ready;
    t_op    op;
    t_value value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

>>> sv/qph_rsp_if.sv
interface qph_rsp_if
    import qph_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  status;
    t_slot slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

>>> sv/quadratic_probe_hash_table_core.sv
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   op[1:0], value[30:0]
// o_rsp     out  valid/ready   status, slot[3:0]
// apb       in   psel/penable  paddr[2:0], pwdata/prdata[31:0], pready
//
// One request at a time: accept it, reduce value mod TABLE_SIZE by reciprocal multiply
// (quotient, then remainder; skipped when TABLE_SIZE is a power of two), then one table
// read per probe through the single memory read port, then post the response. After
// reset the table is swept clear before the first request. The response register
// decouples o_rsp stalls; a new request is taken while it waits.
module quadratic_probe_hash_table_core
    import qph_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qph_req_if.sink           i_req,
    qph_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int          IW      = $clog2(TABLE_SIZE);
    localparam int          CW      = $clog2(TABLE_SIZE + 1);
    localparam int          MW      = VALUE_W + 1;
    localparam int          QW      = VALUE_W - IW + 1;
    localparam int          RW      = VALUE_W + 2;
    localparam int          PW      = VALUE_W + RW;
    localparam int          SH      = VALUE_W + IW;
    localparam logic        IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [IW:0] N_W     = (IW + 1)'(TABLE_SIZE);
    localparam logic [CW-1:0] N_C   = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] LAST_C = CW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] LAST_I = IW'(TABLE_SIZE - 1);
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) / TABLE_SIZE) + 64'd1);
    localparam logic [QW-1:0] N_Q   = QW'(TABLE_SIZE);

    function automatic logic [IW-1:0] mod_add(logic [IW-1:0] a, logic [IW-1:0] b,
                                              logic cin);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b} + {{IW{1'b0}}, cin};
        if (s >= N_W) begin
            s = s - N_W;
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] small_mod(logic [4:0] x);
        logic [IW-1:0] r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if (x == 5'(k)) begin
                r = IW'(k % TABLE_SIZE);
            end
        end
        return r;
    endfunction

    logic [MW-1:0] mem [TABLE_SIZE];

    t_state        r_state, n_state;
    t_coef         r_lin, r_sq;
    logic [IW-1:0] r_clr_idx;
    logic          r_chk_vld;
    logic          r_out_vld;
    logic          r_out_status;
    t_slot         r_out_slot;
    t_op           r_op;
    t_value        r_value;
    logic          r_mod_step;
    logic [QW-1:0] r_quot;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_d;
    logic [IW-1:0] r_inc;
    logic [CW-1:0] r_cnt;
    logic          r_chk_last;
    logic [IW-1:0] r_chk_slot;
    logic [MW-1:0] r_rd_word;
    logic          r_res_status;
    logic [IW-1:0] r_res_slot;

    logic          accept;
    logic          cfg_wr;
    logic          out_free;
    logic          match;
    logic          hit;
    logic          miss_end;
    logic          issue;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          load_out;
    logic [IW-1:0] unit_sum;
    logic [PW-1:0] recip_prod;
    logic [QW-1:0] quot_n;
    logic [IW-1:0] d_init, inc_init;
    logic [SLOT_W+IW-1:0] slot_ext;

    assign accept   = i_req.valid && i_req.ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_vld || o_rsp.ready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_SQUARE) ? {{(DATA_W-COEF_W){1'b0}}, r_sq}
                                               : {{(DATA_W-COEF_W){1'b0}}, r_lin};

    assign d_init   = small_mod(5'(r_lin) + 5'(r_sq));
    assign inc_init = small_mod({1'b0, r_sq} << 1);

    assign match = (r_op == OP_INSERT) ? !r_rd_word[MW-1]
                 : (r_rd_word[MW-1] && (r_rd_word[VALUE_W-1:0] == r_value));
    assign hit      = (r_state == ST_PROBE) && r_chk_vld && match;
    assign miss_end = (r_state == ST_PROBE) && r_chk_vld && !match && r_chk_last;

    // modular adder: advance the probe slot
    assign unit_sum = mod_add(r_slot, r_d, 1'b0);

    // home slot: quotient by reciprocal multiply, then remainder from the low bits
    assign recip_prod = PW'(r_value) * PW'(RECIP);
    assign quot_n     = r_quot * N_Q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_I) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_req.op != OP_INSERT && i_req.op != OP_SEARCH &&
                                 i_req.op != OP_DELETE) begin
                        n_state = ST_RESP;
                    end else if (IS_POW2) begin
                        n_state = ST_PROBE;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (r_mod_step) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (hit || miss_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        issue       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_chk_slot;
        mem_wdata   = '0;
        load_out    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_MOD: begin
            end
            ST_PROBE: begin
                issue = (r_cnt != N_C) && !hit;
                if (hit && r_op == OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, r_value};
                end else if (hit && r_op == OP_DELETE) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b0, r_rd_word[VALUE_W-1:0]};
                end
            end
            ST_RESP: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rd_word <= mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_lin     <= LINEAR_RESET;
            r_sq      <= SQUARE_RESET;
            r_clr_idx <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == REG_SQUARE) begin
                    r_sq <= pwdata[COEF_W-1:0];
                end else begin
                    r_lin <= pwdata[COEF_W-1:0];
                end
            end
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            r_chk_vld <= issue;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_req.op;
            r_value      <= i_req.value;
            r_mod_step   <= 1'b0;
            r_slot       <= i_req.value[IW-1:0];
            r_d          <= d_init;
            r_inc        <= inc_init;
            r_cnt        <= '0;
            r_res_status <= STATUS_FAIL;
            r_res_slot   <= '0;
        end
        if (r_state == ST_MOD) begin
            r_mod_step <= 1'b1;
            if (!r_mod_step) begin
                r_quot <= recip_prod[SH +: QW];
            end else begin
                r_slot <= r_value[IW-1:0] - quot_n[IW-1:0];
            end
        end
        if (issue) begin
            r_chk_slot <= r_slot;
            r_chk_last <= (r_cnt == LAST_C);
            r_cnt      <= r_cnt + 1'b1;
            r_slot     <= unit_sum;
            r_d        <= mod_add(r_d, r_inc, 1'b0);
        end
        if (hit) begin
            r_res_status <= STATUS_OK;
            r_res_slot   <= r_chk_slot;
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= slot_ext[SLOT_W-1:0];
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, r_res_slot};

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

endmodule
